// ===== rtl/ssds_pkg.sv =====
package ssds_pkg;

  // Schedule geometry and number formats.
  localparam int INTERVALS  = 8;
  localparam int OFFSETS    = 7;
  localparam int TIME_WIDTH = 32;
  localparam int BETA_FRAC  = 16;

  localparam int BOUNDS = INTERVALS + 1;
  localparam int BIDX_W = $clog2(BOUNDS);
  localparam int OFF_AW = $clog2(OFFSETS);

  localparam int BETA_W = BETA_FRAC + 1;
  localparam logic [BETA_W-1:0] BETA_ONE = {1'b1, {BETA_FRAC{1'b0}}};

  // Internal arithmetic widths.
  localparam int MARGIN_W = TIME_WIDTH + 2;
  localparam int NEG_W    = TIME_WIDTH + 1;
  localparam int PROD_W   = BETA_W + 1 + TIME_WIDTH;
  localparam int APP_W    = TIME_WIDTH + 1;
  localparam int SUM_W    = TIME_WIDTH + 2;
  localparam int DWELL_W  = TIME_WIDTH + 3;
  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(64'd1 << (BETA_FRAC - 1));

  // Serial divider.
  localparam int DIV_NUM_W = TIME_WIDTH;
  localparam int DIV_DEN_W = NEG_W;
  localparam int DIV_CNT_W = $clog2(BETA_FRAC);

  // Port field widths.
  localparam int IDX_W         = 3;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 32;
  localparam int MIN_DWELL_W   = 31;
  localparam int TOL_W         = 16;
  localparam int STATUS_W      = 2;
  localparam int APPLIED_OUT_W = 32;
  localparam int DWELL_OUT_W   = 34;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DWELL = 4'd0,
    REG_TOLERANCE = 4'd1
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOMINAL = 2'd1,
    ST_APPLIED = 2'd2
  } status_t;

endpackage

// ===== rtl/ssds_div.sv =====
module ssds_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [ssds_pkg::DIV_NUM_W-1:0]      num,
  input  logic [ssds_pkg::DIV_DEN_W-1:0]      den,
  output logic                                done,
  output logic [ssds_pkg::BETA_FRAC-1:0]      quot
);
  import ssds_pkg::*;

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t                state_r, state_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   done_r, done_nxt;
  logic [DIV_DEN_W-1:0]   rem_r;
  logic [DIV_DEN_W-1:0]   den_r;
  logic [BETA_FRAC-1:0]   q_r;
  logic [DIV_DEN_W:0]     shifted;
  logic [DIV_DEN_W:0]     trial;
  logic                   fits;

  // One restoring step per cycle: the remainder stays below the divisor.
  assign shifted = {rem_r, 1'b0};
  assign trial   = shifted - {1'b0, den_r};
  assign fits    = shifted >= {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    case (state_r)
      D_IDLE: begin
        if (start) begin
          state_nxt = D_RUN;
          cnt_nxt   = '0;
        end
      end
      D_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(BETA_FRAC - 1)) begin
          state_nxt = D_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == D_IDLE && start) begin
      rem_r <= DIV_DEN_W'(num);
      den_r <= den;
      q_r   <= '0;
    end else if (state_r == D_RUN) begin
      rem_r <= fits ? trial[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      q_r   <= {q_r[BETA_FRAC-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== rtl/switching_schedule_dwell_scaler_top.sv =====
// A schedule is loaded one boundary per transfer on start/busy: boundaries 0 to 7 are each
// stored and produce no result, while the ninth boundary starts the evaluation and holds
// busy high until it is done. The evaluation first walks the intervals to find the scale
// beta, reading, calculating and deciding for each interval, and running the shared radix-2
// divider for one quotient bit per cycle for every interval whose offset change is negative
// and whose margin lies between zero and that change. It then walks the boundaries again,
// each through read, multiply, round, sum and output steps, with a single multiplier. The
// closing boundary carries no offset, so at most seven intervals can shrink. The eight
// results leave one per pass through the output step, each shown for exactly one cycle with
// out_strobe high; the receiver cannot hold them off, so it must take every result in the
// cycle it appears. A nominal dwell violation marks every result of the schedule with status
// one, otherwise status two flags each interval whose adjusted dwell falls short.
// Configuration writes are always accepted and must only be made while the block is idle.
module switching_schedule_dwell_scaler_top (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  output logic                                       busy,
  input  logic signed [ssds_pkg::TIME_WIDTH-1:0]     in_boundary_time,
  input  logic signed [ssds_pkg::TIME_WIDTH-1:0]     in_raw_offset,
  output logic                                       out_strobe,
  output logic [ssds_pkg::BETA_W-1:0]                out_beta,
  output logic [ssds_pkg::IDX_W-1:0]                 out_interval_index,
  output logic signed [ssds_pkg::APPLIED_OUT_W-1:0]  out_applied_offset,
  output logic signed [ssds_pkg::DWELL_OUT_W-1:0]    out_dwell,
  output logic [ssds_pkg::STATUS_W-1:0]              out_status,
  output logic                                       out_last,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [ssds_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [ssds_pkg::CFG_DATA_W-1:0]            cfg_wdata
);
  import ssds_pkg::*;

  // The first pass (B_*) derives beta; the second pass (E_*) emits one result per interval.
  typedef enum logic [3:0] {
    S_IDLE,
    S_B_RD,
    S_B_CALC,
    S_B_DEC,
    S_B_DIV,
    S_E_RD,
    S_E_MUL,
    S_E_RND,
    S_E_SUM,
    S_E_OUT
  } state_t;

  state_t                       state_r, state_nxt;
  logic [BIDX_W-1:0]            lc_r, lc_nxt;
  logic [BIDX_W-1:0]            bnd_r, bnd_nxt;
  logic [BETA_W-1:0]            beta_r, beta_nxt;
  logic                         nom_fail_r, nom_fail_nxt;
  logic [MIN_DWELL_W-1:0]       min_dwell_r, min_dwell_nxt;
  logic [TOL_W-1:0]             tol_r, tol_nxt;
  logic                         out_strobe_r, out_strobe_nxt;
  logic [BETA_W-1:0]            out_beta_r, out_beta_nxt;
  logic [IDX_W-1:0]             out_idx_r, out_idx_nxt;
  logic [APPLIED_OUT_W-1:0]     out_applied_r, out_applied_nxt;
  logic [DWELL_OUT_W-1:0]       out_dwell_r, out_dwell_nxt;
  status_t                      out_status_r, out_status_nxt;
  logic                         out_last_r, out_last_nxt;

  // Boundary stores; every entry is written before the evaluation reads it.
  logic signed [TIME_WIDTH-1:0] nom_mem [BOUNDS];
  logic signed [TIME_WIDTH-1:0] off_mem [OFFSETS];

  logic signed [TIME_WIDTH-1:0] nom_q_r;
  logic signed [TIME_WIDTH-1:0] off_q_r;
  logic                         off_en_q_r;
  logic signed [TIME_WIDTH-1:0] n_prev_r;
  logic signed [TIME_WIDTH-1:0] off_prev_r;
  logic signed [MARGIN_W-1:0]   margin_r;
  logic signed [NEG_W-1:0]      neg_r;
  logic signed [MARGIN_W-1:0]   neg_tol_r;
  logic signed [DWELL_W-1:0]    thr_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [APP_W-1:0]      applied_r;
  logic signed [SUM_W-1:0]      s_cur_r;
  logic signed [SUM_W-1:0]      s_prev_r;

  logic                         accept;
  logic                         rd_en;
  logic                         lc_off_en;
  logic [OFF_AW-1:0]            lc_off_addr;
  logic                         rd_off_en;
  logic [OFF_AW-1:0]            rd_off_addr;
  logic signed [TIME_WIDTH-1:0] off_cur;
  logic signed [TIME_WIDTH-1:0] bound_s;
  logic signed [TOL_W:0]        tol_s;
  logic signed [BETA_W:0]       beta_s;
  logic signed [PROD_W-1:0]     prod_full;
  logic signed [PROD_W-1:0]     rnd;
  logic signed [DWELL_W-1:0]    dwell;
  logic                         advance;
  logic                         div_start;
  logic                         div_done;
  logic [BETA_FRAC-1:0]         div_quot;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign rd_en     = (state_r == S_B_RD) || (state_r == S_E_RD);

  // Boundary b carries an offset only when it lies in 1..OFFSETS.
  assign lc_off_en   = (lc_r != '0) && (lc_r <= BIDX_W'(OFFSETS));
  assign lc_off_addr = lc_off_en ? OFF_AW'(lc_r - BIDX_W'(1)) : '0;
  assign rd_off_en   = (bnd_r != '0) && (bnd_r <= BIDX_W'(OFFSETS));
  assign rd_off_addr = rd_off_en ? OFF_AW'(bnd_r - BIDX_W'(1)) : '0;

  assign off_cur = off_en_q_r ? off_q_r : '0;
  assign bound_s = {1'b0, min_dwell_r};
  assign tol_s   = {1'b0, tol_r};
  assign beta_s  = {1'b0, beta_r};

  // Applied offset is beta times the offset, rounded to nearest with ties upwards.
  assign prod_full = beta_s * off_cur;
  assign rnd       = prod_r + $signed(RND_HALF);
  assign dwell     = DWELL_W'(s_cur_r) - DWELL_W'(s_prev_r);

  ssds_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (margin_r[DIV_NUM_W-1:0]),
    .den   (neg_r[DIV_DEN_W-1:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      nom_mem[lc_r] <= in_boundary_time;
      if (lc_off_en) begin
        off_mem[lc_off_addr] <= in_raw_offset;
      end
    end
    if (rd_en) begin
      nom_q_r    <= nom_mem[bnd_r];
      off_q_r    <= off_mem[rd_off_addr];
      off_en_q_r <= rd_off_en;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    lc_nxt          = lc_r;
    bnd_nxt         = bnd_r;
    beta_nxt        = beta_r;
    nom_fail_nxt    = nom_fail_r;
    min_dwell_nxt   = min_dwell_r;
    tol_nxt         = tol_r;
    out_strobe_nxt  = 1'b0;
    out_beta_nxt    = out_beta_r;
    out_idx_nxt     = out_idx_r;
    out_applied_nxt = out_applied_r;
    out_dwell_nxt   = out_dwell_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;
    advance         = 1'b0;
    div_start       = 1'b0;

    if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_DWELL: min_dwell_nxt = cfg_wdata[MIN_DWELL_W-1:0];
        REG_TOLERANCE: tol_nxt = cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (lc_r == BIDX_W'(INTERVALS)) begin
            lc_nxt       = '0;
            bnd_nxt      = '0;
            beta_nxt     = BETA_ONE;
            nom_fail_nxt = 1'b0;
            state_nxt    = S_B_RD;
          end else begin
            lc_nxt = lc_r + 1'b1;
          end
        end
      end
      S_B_RD: state_nxt = S_B_CALC;
      S_B_CALC: begin
        if (bnd_r == '0) begin
          bnd_nxt   = bnd_r + 1'b1;
          state_nxt = S_B_RD;
        end else begin
          state_nxt = S_B_DEC;
        end
      end
      S_B_DEC: begin
        if (margin_r < neg_tol_r) begin
          nom_fail_nxt = 1'b1;
        end
        if (neg_r > 0) begin
          if (margin_r < 0) begin
            beta_nxt = '0;
            advance  = 1'b1;
          end else if (margin_r >= MARGIN_W'(neg_r)) begin
            advance = 1'b1;
          end else begin
            div_start = 1'b1;
            state_nxt = S_B_DIV;
          end
        end else begin
          advance = 1'b1;
        end
      end
      S_B_DIV: begin
        if (div_done) begin
          if (BETA_W'(div_quot) < beta_r) begin
            beta_nxt = BETA_W'(div_quot);
          end
          advance = 1'b1;
        end
      end
      S_E_RD:  state_nxt = S_E_MUL;
      S_E_MUL: state_nxt = S_E_RND;
      S_E_RND: state_nxt = S_E_SUM;
      S_E_SUM: state_nxt = S_E_OUT;
      S_E_OUT: begin
        if (bnd_r != '0) begin
          out_strobe_nxt  = 1'b1;
          out_beta_nxt    = beta_r;
          out_idx_nxt     = IDX_W'(bnd_r - BIDX_W'(1));
          out_applied_nxt = applied_r[APPLIED_OUT_W-1:0];
          out_dwell_nxt   = dwell[DWELL_OUT_W-1:0];
          out_last_nxt    = (bnd_r == BIDX_W'(INTERVALS));
          if (nom_fail_r) begin
            out_status_nxt = ST_NOMINAL;
          end else if (dwell < thr_r) begin
            out_status_nxt = ST_APPLIED;
          end else begin
            out_status_nxt = ST_OK;
          end
        end
        if (bnd_r == BIDX_W'(INTERVALS)) begin
          state_nxt = S_IDLE;
        end else begin
          bnd_nxt   = bnd_r + 1'b1;
          state_nxt = S_E_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // After the last interval of the first pass the boundaries are walked again.
    if (advance) begin
      if (bnd_r == BIDX_W'(INTERVALS)) begin
        bnd_nxt   = '0;
        state_nxt = S_E_RD;
      end else begin
        bnd_nxt   = bnd_r + 1'b1;
        state_nxt = S_B_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      lc_r          <= '0;
      bnd_r         <= '0;
      beta_r        <= BETA_ONE;
      nom_fail_r    <= 1'b0;
      min_dwell_r   <= '0;
      tol_r         <= '0;
      out_strobe_r  <= 1'b0;
      out_beta_r    <= BETA_ONE;
      out_idx_r     <= '0;
      out_applied_r <= '0;
      out_dwell_r   <= '0;
      out_status_r  <= ST_OK;
      out_last_r    <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      lc_r          <= lc_nxt;
      bnd_r         <= bnd_nxt;
      beta_r        <= beta_nxt;
      nom_fail_r    <= nom_fail_nxt;
      min_dwell_r   <= min_dwell_nxt;
      tol_r         <= tol_nxt;
      out_strobe_r  <= out_strobe_nxt;
      out_beta_r    <= out_beta_nxt;
      out_idx_r     <= out_idx_nxt;
      out_applied_r <= out_applied_nxt;
      out_dwell_r   <= out_dwell_nxt;
      out_status_r  <= out_status_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  // Datapath registers. Thresholds follow the configuration; the user must change it only when idle.
  always_ff @(posedge clk) begin
    neg_tol_r <= MARGIN_W'(0) - MARGIN_W'(tol_s);
    thr_r     <= DWELL_W'(bound_s) - DWELL_W'(tol_s);
    if (state_r == S_B_CALC) begin
      margin_r   <= MARGIN_W'(nom_q_r) - MARGIN_W'(n_prev_r) - MARGIN_W'(bound_s);
      neg_r      <= NEG_W'(off_prev_r) - NEG_W'(off_cur);
      n_prev_r   <= nom_q_r;
      off_prev_r <= off_cur;
    end
    if (state_r == S_E_MUL) begin
      prod_r <= prod_full;
    end
    if (state_r == S_E_RND) begin
      applied_r <= rnd[BETA_FRAC +: APP_W];
    end
    if (state_r == S_E_SUM) begin
      s_cur_r <= SUM_W'(nom_q_r) + SUM_W'(applied_r);
    end
    if (state_r == S_E_OUT) begin
      s_prev_r <= s_cur_r;
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_beta           = out_beta_r;
  assign out_interval_index = out_idx_r;
  assign out_applied_offset = out_applied_r;
  assign out_dwell          = out_dwell_r;
  assign out_status         = out_status_r;
  assign out_last           = out_last_r;

`ifndef SYNTH
  // The divider only reports a quotient while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_B_DIV))
    else $error("divider finished outside the division wait");

  // The final result of a schedule describes the last interval and leaves the block idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |-> (out_interval_index == IDX_W'(INTERVALS - 1)) && !busy)
    else $error("last result misplaced");

  // Beta never exceeds one.
  assert property (@(posedge clk) disable iff (!rst_n)
    beta_r <= BETA_ONE)
    else $error("beta above one");

  // A result only follows the output step of the emit pass.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_strobe) |-> $past(state_r == S_E_OUT))
    else $error("result outside the emit pass");
`endif

endmodule
